/* sv/hlp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hlp_pkg;

    // Storage and field widths
    localparam int STORE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int KEY_W       = 31;
    localparam int VALUE_W     = 32;
    localparam int PROBE_W     = $clog2(STORE_DEPTH + 1);
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;

    // Stream widths (tdata padded to whole bytes)
    localparam int IN_FIELDS_W  = KEY_W + VALUE_W + SLOT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + VALUE_W + PROBE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Default geometry
    localparam int DEF_NUM_BUCKETS      = 16;
    localparam int DEF_SLOTS_PER_BUCKET = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_RSVD   = 2'd3
    } hlp_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_DELETED   = 3'd4
    } hlp_status_t;

    // Classified request: pos is the home slot, or the slot to clear on delete
    typedef struct packed {
        hlp_cmd_t                   cmd;
        logic [KEY_W-1:0]           key;
        logic signed [VALUE_W-1:0]  value;
        logic [SLOT_W-1:0]          pos;
    } hlp_req_t;

    // Slots in use: bucket count times bucket size, capped at the storage depth
    function automatic int table_slots(input int nb, input int spb);
        int raw;
        raw = nb * spb;
        return (raw > STORE_DEPTH) ? STORE_DEPTH : raw;
    endfunction

endpackage

`default_nettype wire

/* sv/hlp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module hlp_front
    import hlp_pkg::*;
#(
    parameter int NUM_BUCKETS      = DEF_NUM_BUCKETS,
    parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire hlp_cmd_t                   in_cmd,
    input  wire logic [KEY_W-1:0]           in_key,
    input  wire logic signed [VALUE_W-1:0]  in_value,
    input  wire logic [SLOT_W-1:0]          in_slot,
    output logic                            q_valid,
    input  wire logic                       q_ready,
    output hlp_req_t                        q_data
);

    // Quotient by reciprocal: with L = clog2(NUM_BUCKETS), key times
    // ceil(2^(KEY_W+L) / NUM_BUCKETS), shifted right by KEY_W+L, is the exact
    // quotient for every KEY_W-bit key; the factor fits in KEY_W+1 bits.
    localparam int     RECIP_SH = KEY_W + $clog2(NUM_BUCKETS);
    localparam longint RECIP_LL = ((longint'(1) << RECIP_SH) + longint'(NUM_BUCKETS) - 1)
                                  / longint'(NUM_BUCKETS);
    localparam int     RECIP_W  = KEY_W + 1;
    localparam int     PROD_W   = KEY_W + RECIP_W;
    localparam int     RW       = $clog2(NUM_BUCKETS + 1);

    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_LL);
    localparam logic [KEY_W-1:0]   NB_K    = KEY_W'(NUM_BUCKETS);
    localparam logic [SLOT_W-1:0]  SPB_S   = SLOT_W'(SLOTS_PER_BUCKET);

    typedef enum logic [2:0] {
        F_IDLE,
        F_QUOT,
        F_REM,
        F_HOME,
        F_PUSH
    } front_state_t;

    front_state_t      state_reg, state_next;
    hlp_req_t          req_reg, req_next;
    logic [KEY_W-1:0]  quot_reg, quot_next;
    logic [RW-1:0]     rem_reg, rem_next;

    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  rem_full;
    logic [SLOT_W-1:0] home;

    assign in_ready = (state_reg == F_IDLE);
    assign q_valid  = (state_reg == F_PUSH);
    assign q_data   = req_reg;

    // Hash datapath, one step per cycle
    assign prod     = PROD_W'(req_reg.key) * PROD_W'(RECIP_M);
    assign rem_full = req_reg.key - quot_reg * NB_K;
    // The storage depth is a power of two and an uncapped table holds every
    // remainder times bucket size, so the low slot bits are the home slot
    assign home     = SLOT_W'(rem_reg) * SPB_S;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    req_next.cmd   = in_cmd;
                    req_next.key   = in_key;
                    req_next.value = in_value;
                    req_next.pos   = in_slot;
                    if (in_cmd == CMD_INSERT || in_cmd == CMD_SEARCH)
                    begin
                        state_next = F_QUOT;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_QUOT:
            begin
                quot_next  = KEY_W'(prod >> RECIP_SH);
                state_next = F_REM;
            end
            F_REM:
            begin
                rem_next   = RW'(rem_full);
                state_next = F_HOME;
            end
            F_HOME:
            begin
                req_next.pos = home;
                state_next   = F_PUSH;
            end
            F_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            req_reg   <= '0;
            quot_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            quot_reg  <= quot_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* sv/hlp_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module hlp_fifo
    import hlp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire hlp_req_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output hlp_req_t       out_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hlp_req_t            buf_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = buf_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

/* sv/hlp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module hlp_back
    import hlp_pkg::*;
#(
    parameter int NUM_BUCKETS      = DEF_NUM_BUCKETS,
    parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    output logic                        q_ready,
    input  wire hlp_req_t               q_data,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // slot_out, value_out, probe_count
    output logic [STATUS_W-1:0]         m_axis_tuser   // status
);

    localparam int TBL_SLOTS = table_slots(NUM_BUCKETS, SLOTS_PER_BUCKET);
    localparam logic [STORE_DEPTH-1:0] TBL_MASK =
        {STORE_DEPTH{1'b1}} >> (STORE_DEPTH - TBL_SLOTS);
    localparam logic [PROBE_W-1:0] TS_P = PROBE_W'(TBL_SLOTS);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(TBL_SLOTS - 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_PROBE,
        B_OUT
    } back_state_t;

    back_state_t                state_reg, state_next;
    hlp_req_t                   req_reg, req_next;
    logic [SLOT_W-1:0]          addr_reg, addr_next;
    logic [PROBE_W-1:0]         issue_cnt_reg, issue_cnt_next;
    logic [PROBE_W-1:0]         probes_reg, probes_next;
    logic                       rd_live_reg, rd_live_next;
    hlp_status_t                res_status_reg, res_status_next;
    logic [SLOT_W-1:0]          res_slot_reg, res_slot_next;
    logic signed [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic [PROBE_W-1:0]         res_probes_reg, res_probes_next;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]     out_data_reg, out_data_next;
    hlp_status_t                out_status_reg, out_status_next;
    logic [STORE_DEPTH-1:0]     slot_valid_reg;

    // Key/value store and its registered read port
    logic [KEY_W-1:0]           key_mem [STORE_DEPTH];
    logic signed [VALUE_W-1:0]  value_mem [STORE_DEPTH];
    logic [KEY_W-1:0]           rd_key_reg;
    logic signed [VALUE_W-1:0]  rd_value_reg;
    logic                       rd_valid_reg;
    logic [SLOT_W-1:0]          rd_addr_reg;

    logic                       is_insert;
    logic                       hit;
    logic                       last_probe;
    logic                       issue;
    logic                       mem_we;
    logic                       del_go;
    logic                       out_free;
    logic                       out_load;
    logic [PROBE_W-1:0]         probe_num;

    assign is_insert  = (req_reg.cmd == CMD_INSERT);
    assign probe_num  = probes_reg + 1'b1;
    assign hit        = rd_live_reg && (is_insert ? !rd_valid_reg
                                     : (rd_valid_reg && rd_key_reg == req_reg.key));
    assign last_probe = rd_live_reg && (probe_num == TS_P);
    assign issue      = (state_reg == B_PROBE) && !hit && (issue_cnt_reg != TS_P);
    assign mem_we     = (state_reg == B_PROBE) && hit && is_insert;
    assign q_ready    = (state_reg == B_IDLE);
    assign del_go     = (state_reg == B_IDLE) && q_valid && (q_data.cmd == CMD_DELETE)
                        && ({1'b0, q_data.pos} < TS_P);
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign out_load   = (state_reg == B_OUT) && out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // Control: pop a request, probe one slot per cycle, hand the result over
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        issue_cnt_next  = issue_cnt_reg;
        probes_next     = probes_reg;
        rd_live_next    = issue;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        res_probes_next = res_probes_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    req_next        = q_data;
                    addr_next       = q_data.pos;
                    issue_cnt_next  = '0;
                    probes_next     = '0;
                    res_value_next  = '0;
                    res_probes_next = '0;
                    unique case (q_data.cmd)
                        CMD_INSERT, CMD_SEARCH:
                        begin
                            state_next = B_PROBE;
                        end
                        CMD_DELETE:
                        begin
                            res_status_next = ST_DELETED;
                            res_slot_next   = q_data.pos;
                            state_next      = B_OUT;
                        end
                        CMD_RSVD:
                        begin
                            res_status_next = ST_NOT_FOUND;
                            res_slot_next   = '0;
                            state_next      = B_OUT;
                        end
                        default:
                        begin
                            state_next = B_OUT;
                        end
                    endcase
                end
            end
            B_PROBE:
            begin
                if (issue)
                begin
                    addr_next      = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (rd_live_reg)
                begin
                    probes_next = probe_num;
                end
                if (hit)
                begin
                    res_status_next = is_insert ? ST_INSERTED : ST_FOUND;
                    res_slot_next   = rd_addr_reg;
                    res_value_next  = is_insert ? '0 : rd_value_reg;
                    res_probes_next = probe_num;
                    state_next      = B_OUT;
                end
                else if (last_probe)
                begin
                    res_status_next = is_insert ? ST_FULL : ST_NOT_FOUND;
                    res_slot_next   = '0;
                    res_value_next  = '0;
                    res_probes_next = TS_P;
                    state_next      = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = OUT_TDATA_W'({res_probes_reg, res_value_reg,
                                                    res_slot_reg});
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            req_reg        <= '0;
            addr_reg       <= '0;
            issue_cnt_reg  <= '0;
            probes_reg     <= '0;
            rd_live_reg    <= 1'b0;
            res_status_reg <= ST_NOT_FOUND;
            res_slot_reg   <= '0;
            res_value_reg  <= '0;
            res_probes_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= ST_NOT_FOUND;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            addr_reg       <= addr_next;
            issue_cnt_reg  <= issue_cnt_next;
            probes_reg     <= probes_next;
            rd_live_reg    <= rd_live_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_value_reg  <= res_value_next;
            res_probes_reg <= res_probes_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    // Valid marks: set by a successful insert, cleared by delete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else
        begin
            if (mem_we)
            begin
                slot_valid_reg[rd_addr_reg] <= 1'b1;
            end
            if (del_go)
            begin
                slot_valid_reg[q_data.pos] <= 1'b0;
            end
        end
    end

    // Store write and read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[rd_addr_reg]   <= req_reg.key;
            value_mem[rd_addr_reg] <= req_reg.value;
        end
        rd_key_reg   <= key_mem[addr_reg];
        rd_value_reg <= value_mem[addr_reg];
        rd_valid_reg <= slot_valid_reg[addr_reg];
        rd_addr_reg  <= addr_reg;
    end

    // No slot outside the table is ever marked valid
    a_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_valid_reg & ~TBL_MASK) == '0)
        else $error("valid mark set outside the table");

    // A full report means every slot of the table is occupied
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_status_reg == ST_FULL) |-> ($countones(slot_valid_reg) == TBL_SLOTS))
        else $error("table full reported with a free slot");

    // An insert never lands on an occupied slot
    a_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !slot_valid_reg[rd_addr_reg])
        else $error("insert overwrote a valid slot");

    // A result never counts more probes than the table has slots
    a_probes: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (res_probes_reg <= TS_P))
        else $error("probe count beyond table size");

    // The next read is issued only while the lap is unfinished
    a_issue: assert property (@(posedge clk) disable iff (!rst_n)
        rd_live_reg |-> (probes_reg < TS_P))
        else $error("probe issued past one lap");

endmodule

`default_nettype wire

/* sv/hash_table_linear_probe.sv */
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing hash table with linear probing over up to 64 slots
// (NUM_BUCKETS * SLOTS_PER_BUCKET, capped at 64). Each request on the s_axis
// side gives exactly one result on the m_axis side, in order. A front stage
// finds the home slot (key mod NUM_BUCKETS by reciprocal multiplication, times
// SLOTS_PER_BUCKET), working out quotient, remainder and home slot in turn for
// an insert or search and passing a delete or the reserved command straight
// on; it takes a new request only once the last one is in the queue. A
// two-entry queue then feeds the probe engine, which reads one slot per cycle
// from the key/value store and takes a new request only once the result of
// the last one is handed to the output register. The slower of the two
// stages sets the sustained rate, normally the probe engine; a stalled m_axis
// side backs up through the queue into s_axis_tready.
// Valid marks are cleared at reset; the block is ready right after reset.
module hash_table_linear_probe
    import hlp_pkg::*;
#(
    parameter int NUM_BUCKETS      = DEF_NUM_BUCKETS,
    parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,   // key, value_in, slot_in
    input  wire logic [CMD_W-1:0]        s_axis_tuser,   // command
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,   // slot_out, value_out, probe_count
    output logic [STATUS_W-1:0]          m_axis_tuser    // status
);

    hlp_cmd_t                   in_cmd;
    logic [KEY_W-1:0]           in_key;
    logic signed [VALUE_W-1:0]  in_value;
    logic [SLOT_W-1:0]          in_slot;

    logic       fq_valid;
    logic       fq_ready;
    hlp_req_t   fq_data;
    logic       qb_valid;
    logic       qb_ready;
    hlp_req_t   qb_data;

    // Request unpacking
    assign in_cmd   = hlp_cmd_t'(s_axis_tuser);
    assign in_key   = s_axis_tdata[KEY_W-1:0];
    assign in_value = s_axis_tdata[KEY_W+VALUE_W-1:KEY_W];
    assign in_slot  = s_axis_tdata[IN_FIELDS_W-1:KEY_W+VALUE_W];

    hlp_front #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .in_key   (in_key),
        .in_value (in_value),
        .in_slot  (in_slot),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    hlp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    hlp_back #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_data        (qb_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* sim/hash_table_linear_probe_test.sv */
`timescale 1ns / 1ps

module hash_table_linear_probe_test;
    import hlp_pkg::*;

    // Geometry under test and the slot count it gives
    localparam int N_BUCKETS    = DEF_NUM_BUCKETS;
    localparam int BUCKET_SLOTS = DEF_SLOTS_PER_BUCKET;
    localparam int NUM_SLOTS    = (N_BUCKETS * BUCKET_SLOTS > STORE_DEPTH) ?
                                  STORE_DEPTH : N_BUCKETS * BUCKET_SLOTS;

    localparam int RANDOM_OPS   = 1126;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 150;
    localparam int POOL_MAX     = 64;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    typedef struct {
        hlp_cmd_t                  cmd;
        logic [KEY_W-1:0]          key;
        logic [VALUE_W-1:0]        value;
        logic [SLOT_W-1:0]         slot;
    } table_op_t;

    typedef struct {
        hlp_status_t               status;
        logic [SLOT_W-1:0]         slot;
        logic [VALUE_W-1:0]        value;
        logic [PROBE_W-1:0]        probes;
    } table_reply_t;

    typedef struct {
        table_op_t                 op;
        bit                        fixed;
        table_reply_t              reply;
    } directed_row_t;

    typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;    // key, value_in, slot_in
    logic [CMD_W-1:0]        s_axis_tuser = CMD_INSERT;  // command
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;         // slot_out, value_out, probe_count
    logic [STATUS_W-1:0]     m_axis_tuser;         // status

    hash_table_linear_probe #(
        .NUM_BUCKETS      (N_BUCKETS),
        .SLOTS_PER_BUCKET (BUCKET_SLOTS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the slot store
    bit                  shadow_valid [NUM_SLOTS];
    logic [KEY_W-1:0]    shadow_key   [NUM_SLOTS];
    logic [VALUE_W-1:0]  shadow_value [NUM_SLOTS];

    table_reply_t        pending_replies [$];
    directed_row_t       directed_rows [$];
    logic [KEY_W-1:0]    key_pool [$];

    // Request currently offered by the sender
    table_op_t           offered_op;
    bit                  offered_fixed = 1'b0;
    table_reply_t        offered_reply;

    int                  error_count = 0;
    int                  accepted_cnt = 0;
    int                  reply_cnt = 0;
    int                  burst_left = 0;

    // Receiver stall state
    int                  hold_left = 0;
    bit                  hold_done = 1'b0;
    int                  pat_age = 0;
    logic [15:0]         ready_pat = 16'hFFFF;
    logic [3:0]          pat_pos = '0;

    function automatic int home_of(logic [KEY_W-1:0] key);
        return ((key % N_BUCKETS) * BUCKET_SLOTS) % NUM_SLOTS;
    endfunction

    // Applies one request to the shadow table and returns the expected reply
    function automatic table_reply_t apply_table_op(table_op_t op);
        table_reply_t r;
        int pos;
        r = '{ST_NOT_FOUND, '0, '0, '0};
        case (op.cmd)
            CMD_INSERT:
            begin
                pos = home_of(op.key);
                r.status = ST_FULL;
                r.probes = PROBE_W'(NUM_SLOTS);
                for (int p = 1; p <= NUM_SLOTS; p++)
                begin
                    if (!shadow_valid[pos])
                    begin
                        shadow_valid[pos] = 1'b1;
                        shadow_key[pos]   = op.key;
                        shadow_value[pos] = op.value;
                        r = '{ST_INSERTED, SLOT_W'(pos), '0, PROBE_W'(p)};
                        return r;
                    end
                    pos = (pos + 1 == NUM_SLOTS) ? 0 : pos + 1;
                end
            end
            CMD_SEARCH:
            begin
                pos = home_of(op.key);
                r.probes = PROBE_W'(NUM_SLOTS);
                for (int p = 1; p <= NUM_SLOTS; p++)
                begin
                    if (shadow_valid[pos] && shadow_key[pos] == op.key)
                    begin
                        r = '{ST_FOUND, SLOT_W'(pos), shadow_value[pos], PROBE_W'(p)};
                        return r;
                    end
                    pos = (pos + 1 == NUM_SLOTS) ? 0 : pos + 1;
                end
            end
            CMD_DELETE:
            begin
                if (op.slot < NUM_SLOTS)
                    shadow_valid[op.slot] = 1'b0;
                r = '{ST_DELETED, op.slot, '0, '0};
            end
            default:
                r = '{ST_NOT_FOUND, '0, '0, '0};
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: result %0d %s: got %0h, expected %0h",
                 $realtime, reply_cnt, field, got, want);
        error_count++;
    endtask

    task automatic add_row(input hlp_cmd_t cmd, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value, input logic [SLOT_W-1:0] slot,
                           input bit fixed, input hlp_status_t status,
                           input logic [SLOT_W-1:0] slot_out,
                           input logic [PROBE_W-1:0] probes);
        directed_row_t row;
        row.op    = '{cmd, key, value, slot};
        row.fixed = fixed;
        row.reply = '{status, slot_out, '0, probes};
        directed_rows.push_back(row);
    endtask

    // Offer one request; entered and left at a falling edge
    task automatic offer(input table_op_t op, input bit fixed, input table_reply_t reply);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, op.slot, op.value, op.key};
        s_axis_tuser <= op.cmd;
        s_axis_tvalid <= 1'b1;
        offered_op    = op;
        offered_fixed = fixed;
        offered_reply = reply;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Check results, then record accepted requests
    always @(posedge clk)
    begin
        table_reply_t want;
        table_reply_t pred;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_replies.size() == 0)
                    report_mismatch("unexpected result, status", 64'(m_axis_tuser), '0);
                else
                begin
                    want = pending_replies.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                    if (m_axis_tdata[SLOT_W-1:0] !== want.slot)
                        report_mismatch("slot_out", 64'(m_axis_tdata[SLOT_W-1:0]),
                                        64'(want.slot));
                    if (m_axis_tdata[SLOT_W +: VALUE_W] !== want.value)
                        report_mismatch("value_out", 64'(m_axis_tdata[SLOT_W +: VALUE_W]),
                                        64'(want.value));
                    if (m_axis_tdata[SLOT_W + VALUE_W +: PROBE_W] !== want.probes)
                        report_mismatch("probe_count",
                                        64'(m_axis_tdata[SLOT_W + VALUE_W +: PROBE_W]),
                                        64'(want.probes));
                end
                reply_cnt++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred = apply_table_op(offered_op);
                pending_replies.push_back(offered_fixed ? offered_reply : pred);
                accepted_cnt++;
            end
        end
    end

    // Receiver: rotating ready patterns plus one long hold-off
    always @(negedge clk)
    begin
        if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (pat_age == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1: ready_pat = 16'hFFFF;
                    2:    ready_pat = 16'hAAAA;
                    3:    ready_pat = 16'hEF7B;
                    default: ready_pat = 16'($urandom);
                endcase
                pat_age = 48;
            end
            pat_age--;
            m_axis_tready <= ready_pat[pat_pos];
            pat_pos <= pat_pos + 1'b1;
        end
    end

    // Run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial
    begin
        table_op_t     op;
        table_reply_t  no_reply;
        op_mix_t       mix;
        int            run_len;
        int            pick;
        int            ins_pct;
        int            srch_pct;
        int            del_pct;
        int            issued;

        no_reply = '{ST_NOT_FOUND, '0, '0, '0};
        issued = 0;

        // Directed rows; probes and slots traced by hand where typed
        add_row(CMD_SEARCH, 31'd0, 32'd0, 6'd0, 1, ST_NOT_FOUND, 6'd0, PROBE_W'(NUM_SLOTS));
        add_row(CMD_SEARCH, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1, ST_NOT_FOUND, 6'd0,
                PROBE_W'(NUM_SLOTS));
        add_row(CMD_INSERT, 31'd0, 32'h7FFF_FFFF, 6'd0, 1, ST_INSERTED, 6'd0, 7'd1);
        add_row(CMD_INSERT, 31'd16, 32'h8000_0000, 6'd0, 1, ST_INSERTED, 6'd1, 7'd2);
        add_row(CMD_INSERT, 31'h7FFF_FFFF, 32'h1234_5678, 6'd0, 1, ST_INSERTED, 6'd60, 7'd1);
        add_row(CMD_INSERT, 31'h7FFF_FFEF, 32'hFFFF_FFFF, 6'd0, 0, ST_INSERTED, 6'd0, 7'd0);
        // duplicate key lands in the next free slot
        add_row(CMD_INSERT, 31'h7FFF_FFFF, 32'hCAFE_0001, 6'd0, 0, ST_INSERTED, 6'd0, 7'd0);
        add_row(CMD_INSERT, 31'd15, 32'd15, 6'd0, 0, ST_INSERTED, 6'd0, 7'd0);
        // wraps past the table end
        add_row(CMD_INSERT, 31'd31, 32'd31, 6'd0, 0, ST_INSERTED, 6'd0, 7'd0);
        add_row(CMD_SEARCH, 31'h7FFF_FFFF, 32'd0, 6'd0, 0, ST_FOUND, 6'd0, 7'd0);
        add_row(CMD_SEARCH, 31'd16, 32'd0, 6'd0, 0, ST_FOUND, 6'd0, 7'd0);
        add_row(CMD_SEARCH, 31'd31, 32'd0, 6'd0, 0, ST_FOUND, 6'd0, 7'd0);
        add_row(CMD_DELETE, 31'd0, 32'd0, 6'd0, 1, ST_DELETED, 6'd0, 7'd0);
        // empty slot must not stop the search
        add_row(CMD_SEARCH, 31'd16, 32'd0, 6'd0, 0, ST_FOUND, 6'd0, 7'd0);
        add_row(CMD_SEARCH, 31'd0, 32'd0, 6'd0, 0, ST_NOT_FOUND, 6'd0, 7'd0);
        add_row(CMD_DELETE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1, ST_DELETED, 6'd63, 7'd0);
        // already empty
        add_row(CMD_DELETE, 31'd0, 32'd0, 6'd63, 1, ST_DELETED, 6'd63, 7'd0);
        add_row(CMD_RSVD, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1, ST_NOT_FOUND, 6'd0, 7'd0);
        add_row(CMD_INSERT, 31'd32, 32'h0000_0001, 6'd0, 0, ST_INSERTED, 6'd0, 7'd0);
        add_row(CMD_DELETE, 31'd0, 32'd0, 6'd60, 1, ST_DELETED, 6'd60, 7'd0);
        // second copy of the duplicate is found now
        add_row(CMD_SEARCH, 31'h7FFF_FFFF, 32'd0, 6'd0, 0, ST_FOUND, 6'd0, 7'd0);
        add_row(CMD_INSERT, 31'h5555_5555, 32'h5A5A_5A5A, 6'd42, 0, ST_INSERTED, 6'd0, 7'd0);
        add_row(CMD_SEARCH, 31'h5555_5555, 32'd0, 6'd0, 0, ST_FOUND, 6'd0, 7'd0);
        add_row(CMD_SEARCH, 31'h2AAA_AAAA, 32'd0, 6'd21, 0, ST_NOT_FOUND, 6'd0, 7'd0);

        // Reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer(directed_rows[i].op, directed_rows[i].fixed, directed_rows[i].reply);
            if (directed_rows[i].op.cmd == CMD_INSERT)
                key_pool.push_back(directed_rows[i].op.key);
        end

        // Random runs with varying mix; the first run uses the insert-heavy fill mix
        mix = MIX_FILL;
        while (issued < RANDOM_OPS)
        begin
            run_len = $urandom_range(20, 90);
            if (run_len > RANDOM_OPS - issued)
                run_len = RANDOM_OPS - issued;
            case (mix)
                MIX_FILL:     begin ins_pct = 85; srch_pct = 12; del_pct = 2;  end
                MIX_BALANCED: begin ins_pct = 40; srch_pct = 35; del_pct = 20; end
                default:      begin ins_pct = 10; srch_pct = 30; del_pct = 58; end
            endcase
            repeat (run_len)
            begin
                pick = $urandom_range(0, 99);
                op.key   = KEY_W'($urandom);
                op.value = $urandom;
                op.slot  = SLOT_W'($urandom_range(0, 63));
                case ($urandom_range(0, 7))
                    0: op.value = 32'h7FFF_FFFF;
                    1: op.value = 32'h8000_0000;
                    default: ;
                endcase
                if (pick < ins_pct)
                begin
                    op.cmd = CMD_INSERT;
                    if ($urandom_range(0, 1) == 0)
                        op.key = KEY_W'($urandom_range(0, 255));
                    key_pool.push_back(op.key);
                    if (key_pool.size() > POOL_MAX)
                        void'(key_pool.pop_front());
                end
                else if (pick < ins_pct + srch_pct)
                begin
                    op.cmd = CMD_SEARCH;
                    if (key_pool.size() > 0 && $urandom_range(0, 9) < 7)
                        op.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end
                else if (pick < ins_pct + srch_pct + del_pct)
                    op.cmd = CMD_DELETE;
                else
                    op.cmd = CMD_RSVD;
                offer(op, 1'b0, no_reply);
                issued++;
            end
            mix = op_mix_t'($urandom_range(0, 2));
        end

        // Drain
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
